// ===== hdl/motor_speed_ramp_macros.svh =====
// ----------------------------------------------------------------------------
// Motor speed ramp assertion macros
// Shared property wrappers for the speed ramp checkers.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_RAMP_MACROS_SVH
`define MOTOR_SPEED_RAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MSR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("motor_speed_ramp: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define MSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("motor_speed_ramp: next-cycle check failed");

`endif

// ===== hdl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor speed ramp package
// Field types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package msr_pkg;

    typedef logic signed [20:0] t_speed;
    typedef logic        [15:0] t_tick;
    typedef logic        [23:0] t_rate;
    typedef logic        [20:0] t_step;
    typedef logic        [0:0]  t_cfg_idx;

    localparam t_cfg_idx REG_ACCEL_RATE = 1'b0;
    localparam t_cfg_idx REG_DECEL_RATE = 1'b1;

    // Gap under which the set speed snaps to the target (0.1 rpm).
    localparam int SNAP_GAP  = 10;
    // Set speeds under this magnitude are forced to zero (0.05 rpm).
    localparam int ZERO_BAND = 5;

    // floor(p / 1e6) = floor((p >> 6) / 15625); the second divide is a
    // multiply by ceil(2^48 / 15625) and a shift by 48, exact for 34-bit inputs.
    localparam int          PRE_SHIFT   = 6;
    localparam int          RECIP_SHIFT = 48;
    localparam logic [34:0] RECIP       = 35'd18014398510;
    localparam logic [16:0] RECIP_HI    = RECIP[34:18];
    localparam logic [17:0] RECIP_LO    = RECIP[17:0];

    // Load strobes for the step pipeline stages.
    typedef struct packed {
        logic ld_b;
        logic ld_c;
        logic ld_d;
    } t_pipe_ld;

endpackage

// ===== hdl/msr_step_div.sv =====
// ----------------------------------------------------------------------------
// Ramp step unit
// Computes floor(rate * tick_us / 1e6) over three registered stages.
// ----------------------------------------------------------------------------
module msr_step_div (
    input  logic             i_clk,
    input  msr_pkg::t_pipe_ld i_ld,
    input  msr_pkg::t_rate   i_rate,
    input  msr_pkg::t_tick   i_tick,
    output msr_pkg::t_step   o_step
);
    import msr_pkg::*;

    logic [39:0] r_prod;
    logic [33:0] r_pp_hh;
    logic [34:0] r_pp_hl;
    logic [33:0] r_pp_lh;
    logic [34:0] r_pp_ll;
    t_step       r_step;

    logic [33:0] w_x;
    logic [68:0] w_sum;

    assign w_x = r_prod[39:PRE_SHIFT];

    assign w_sum = ({35'd0, r_pp_hh} << 35) + ({34'd0, r_pp_hl} << 17)
                 + ({35'd0, r_pp_lh} << 18) + {34'd0, r_pp_ll};

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_b) begin
            r_prod <= 40'(i_rate) * 40'(i_tick);
        end
        if (i_ld.ld_c) begin
            r_pp_hh <= 34'(w_x[33:17]) * 34'(RECIP_HI);
            r_pp_hl <= 35'(w_x[33:17]) * 35'(RECIP_LO);
            r_pp_lh <= 34'(w_x[16:0])  * 34'(RECIP_HI);
            r_pp_ll <= 35'(w_x[16:0])  * 35'(RECIP_LO);
        end
        if (i_ld.ld_d) begin
            r_step <= w_sum[68:RECIP_SHIFT];
        end
    end

    assign o_step = r_step;

endmodule

// ===== hdl/motor_speed_ramp.sv =====
// ----------------------------------------------------------------------------
// Motor speed ramp
// Slew-rate limiter for a signed speed setpoint in 0.01 rpm units.
// ----------------------------------------------------------------------------
// Takes one request per clock while o_stall is low and returns one set speed
// per request via stages a, b, c, d and the output register. The step for
// both accel and decel rates comes from a three-stage pipeline (rate times
// tick, reciprocal partial products, sum); the set-speed update is a
// combinational compare, add and clamp on the stored set speed, so
// back-to-back ticks see the result of the one before. The user writes rates
// only with no tick in flight (not enforced); the config port is always ready.
module motor_speed_ramp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  msr_pkg::t_speed   i_target_speed,
    input  msr_pkg::t_tick    i_tick_us,
    output logic              o_valid,
    input  logic              i_stall,
    output msr_pkg::t_speed   o_set_speed,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  msr_pkg::t_cfg_idx i_cfg_index,
    input  msr_pkg::t_rate    i_cfg_data
);
    import msr_pkg::*;

    t_rate    r_accel_rate;
    t_rate    r_decel_rate;

    logic     r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_out_valid;
    t_speed   r_a_target, r_b_target, r_c_target, r_d_target;
    t_tick    r_a_tick;
    t_speed   r_set_speed;
    t_speed   n_set_speed;

    logic     w_rdy_out, w_rdy_d, w_rdy_c, w_rdy_b, w_rdy_a;
    t_pipe_ld w_ld;
    t_step    w_step_acc, w_step_dec;

    // Stage fills when empty or when its content moves on.
    assign w_rdy_out = !r_out_valid || !i_stall;
    assign w_rdy_d   = !r_d_valid || w_rdy_out;
    assign w_rdy_c   = !r_c_valid || w_rdy_d;
    assign w_rdy_b   = !r_b_valid || w_rdy_c;
    assign w_rdy_a   = !r_a_valid || w_rdy_b;

    assign w_ld.ld_b = w_rdy_b;
    assign w_ld.ld_c = w_rdy_c;
    assign w_ld.ld_d = w_rdy_d;

    assign o_stall     = !w_rdy_a;
    assign o_valid     = r_out_valid;
    assign o_set_speed = r_set_speed;
    assign o_cfg_ready = 1'b1;

    msr_step_div u_step_acc (
        .i_clk  (i_clk),
        .i_ld   (w_ld),
        .i_rate (r_accel_rate),
        .i_tick (r_a_tick),
        .o_step (w_step_acc)
    );

    msr_step_div u_step_dec (
        .i_clk  (i_clk),
        .i_ld   (w_ld),
        .i_rate (r_decel_rate),
        .i_tick (r_a_tick),
        .o_step (w_step_dec)
    );

    // Set-speed update
    logic signed [22:0] w_s, w_t, w_diff, w_diff_mag, w_s_mag, w_t_mag;
    logic signed [22:0] w_step, w_mv, w_ramp, w_ramp_mag;
    logic               w_snap, w_rev, w_acc;

    always_comb begin
        w_s        = {{2{r_set_speed[20]}}, r_set_speed};
        w_t        = {{2{r_d_target[20]}}, r_d_target};
        w_diff     = w_t - w_s;
        w_diff_mag = w_diff[22] ? -w_diff : w_diff;
        w_s_mag    = w_s[22] ? -w_s : w_s;
        w_t_mag    = w_t[22] ? -w_t : w_t;
        w_snap     = w_diff_mag < 23'(SNAP_GAP);
        w_rev      = (!w_s[22] && (w_s != '0) && w_t[22])
                  || (w_s[22] && !w_t[22] && (w_t != '0));
        w_acc      = !w_rev && (w_t_mag > w_s_mag);
        w_step     = w_acc ? {2'b00, w_step_acc} : {2'b00, w_step_dec};
        w_mv       = (w_diff_mag < w_step) ? w_diff_mag : w_step;
        if (w_rev) begin
            // Head for zero and stop there.
            if (w_step < w_s_mag) begin
                w_ramp = w_s[22] ? w_s + w_step : w_s - w_step;
            end else begin
                w_ramp = '0;
            end
        end else begin
            w_ramp = w_diff[22] ? w_s - w_mv : w_s + w_mv;
        end
        w_ramp_mag = w_ramp[22] ? -w_ramp : w_ramp;
        if (w_snap) begin
            n_set_speed = r_d_target;
        end else if (w_ramp_mag < 23'(ZERO_BAND)) begin
            n_set_speed = '0;
        end else begin
            n_set_speed = w_ramp[20:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rate <= '0;
            r_decel_rate <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_set_speed  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ACCEL_RATE: r_accel_rate <= i_cfg_data;
                    REG_DECEL_RATE: r_decel_rate <= i_cfg_data;
                    default:        r_accel_rate <= r_accel_rate;
                endcase
            end
            if (w_rdy_a)   r_a_valid   <= i_valid;
            if (w_rdy_b)   r_b_valid   <= r_a_valid;
            if (w_rdy_c)   r_c_valid   <= r_b_valid;
            if (w_rdy_d)   r_d_valid   <= r_c_valid;
            if (w_rdy_out) r_out_valid <= r_d_valid;
            // Advance the stored speed only on a real request.
            if (w_rdy_out && r_d_valid) begin
                r_set_speed <= n_set_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_target <= i_target_speed;
            r_a_tick   <= i_tick_us;
        end
        if (w_rdy_b) r_b_target <= r_a_target;
        if (w_rdy_c) r_c_target <= r_b_target;
        if (w_rdy_d) r_d_target <= r_c_target;
    end

endmodule

// ===== hdl/msr_checker.sv =====
// ----------------------------------------------------------------------------
// Motor speed ramp checker
// Port-level checks on the speed ramp, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_speed_ramp_macros.svh"

module msr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input msr_pkg::t_speed o_set_speed
);

    // Reset empties the output stage.
    `MSR_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, !o_valid)

    // Back-pressure upstream only when the output is full and held.
    `MSR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // A held result keeps its value.
    `MSR_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_valid && i_stall,
                     o_valid && $stable(o_set_speed))

endmodule

bind motor_speed_ramp msr_checker u_msr_checker (.*);
